FILE: src/lpe_pkg.sv
// ----------------------------------------------------------------------------
// lpe_pkg
// Types and constants shared by the node polynomial evaluator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lpe_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned MANT_W      = 32;
  localparam int unsigned ACC_W       = 64;
  localparam int unsigned SHV_W       = 95;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] REG_ACTIVE_COUNT   = 2'd0;
  localparam logic [1:0] REG_SCALE_MANTISSA = 2'd1;
  localparam logic [1:0] REG_SCALE_EXPONENT = 2'd2;

  localparam logic [1:0] MSEL_RE_A = 2'd0;
  localparam logic [1:0] MSEL_RE_B = 2'd1;
  localparam logic [1:0] MSEL_IM_A = 2'd2;
  localparam logic [1:0] MSEL_IM_B = 2'd3;

  localparam logic [30:0] SCALE_MANT_RESET = 31'd1073741824;

  typedef struct packed {
    logic                          operation;
    logic [7:0]                    index;
    logic signed [COORD_WIDTH-1:0] value_re;
    logic signed [COORD_WIDTH-1:0] value_im;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] result_re;
    logic signed [COORD_WIDTH-1:0] result_im;
    logic                          overflow;
  } out_item_t;

  typedef struct packed {
    logic [8:0]         active_count;
    logic [30:0]        scale_mantissa;
    logic signed [7:0]  scale_exponent;
  } lpe_cfg_t;

  typedef struct packed {
    logic       start;
    logic       load;
    logic       rd;
    logic       diff;
    logic       ncnt;
    logic       nap_d;
    logic       nap_p;
    logic       mul;
    logic [1:0] msel;
    logic       sc;
    logic       scsel;
    logic       shf;
    logic       outld;
  } lpe_cmd_t;

  typedef struct packed {
    logic nodes_done;
  } lpe_sts_t;

endpackage

`default_nettype wire

FILE: src/lpe_ctrl.sv
// ----------------------------------------------------------------------------
// lpe_ctrl
// Sequencer: per node read, difference, normalize, four-step complex
// multiply, normalize; then scale, shift and saturate into the output.
// ----------------------------------------------------------------------------
`default_nettype none

module lpe_ctrl
  import lpe_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_op_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire lpe_sts_t sts_i,
  output lpe_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHK, ST_RD, ST_DIFF, ST_NCD, ST_NAD, ST_MUL,
    ST_NCP, ST_NAP, ST_SC0, ST_SC1, ST_SHF, ST_OUT
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] msel_q, msel_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    cmd_o.msel  = msel_q;
    state_d     = state_q;
    msel_d      = msel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OP_EVAL) begin
            cmd_o.start = 1'b1;
            state_d     = ST_CHK;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_CHK:  state_d = sts_i.nodes_done ? ST_SC0 : ST_RD;
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_NCD;
      end
      ST_NCD: begin
        cmd_o.ncnt = 1'b1;
        state_d    = ST_NAD;
      end
      ST_NAD: begin
        cmd_o.nap_d = 1'b1;
        msel_d      = MSEL_RE_A;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        msel_d    = msel_q + 2'd1;
        if (msel_q == MSEL_IM_B) state_d = ST_NCP;
      end
      ST_NCP: begin
        cmd_o.ncnt = 1'b1;
        state_d    = ST_NAP;
      end
      ST_NAP: begin
        cmd_o.nap_p = 1'b1;
        state_d     = ST_CHK;
      end
      ST_SC0: begin
        cmd_o.sc    = 1'b1;
        cmd_o.scsel = 1'b0;
        state_d     = ST_SC1;
      end
      ST_SC1: begin
        cmd_o.sc    = 1'b1;
        cmd_o.scsel = 1'b1;
        state_d     = ST_SHF;
      end
      ST_SHF: begin
        cmd_o.shf = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.outld = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      msel_q      <= MSEL_RE_A;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      msel_q      <= msel_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/lpe_dp.sv
// ----------------------------------------------------------------------------
// lpe_dp
// Datapath: node memory, shared 32x32 multiplier, block floating point
// normalizer, final scaling and Q16.16 saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module lpe_dp
  import lpe_pkg::*;
#(
  parameter int unsigned MAX_NODES = 256
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_item_t in_item_i,
  input  wire lpe_cfg_t cfg_i,
  input  wire lpe_cmd_t cmd_i,
  output lpe_sts_t      sts_o,
  output out_item_t     out_item_o
);

  localparam int unsigned AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
  localparam int unsigned CW    = (CNT_W > 9) ? CNT_W : 9;
  localparam int unsigned EXP_W = CNT_W + 8;
  localparam int unsigned KW    = EXP_W + 1;

  localparam logic signed [SHV_W-1:0] Q_MAX = SHV_W'(64'sh7FFFFFFF);
  localparam logic signed [SHV_W-1:0] Q_MIN = -SHV_W'(64'sh80000000);

  logic [2*COORD_WIDTH-1:0] mem [MAX_NODES];
  logic [2*COORD_WIDTH-1:0] rdata_q;

  logic [CNT_W-1:0]              loaded_q, n_q, i_q;
  logic signed [COORD_WIDTH-1:0] z_re_q, z_im_q;
  logic signed [MANT_W-1:0]      pr_q, pi_q, dr_q, di_q;
  logic signed [EXP_W-1:0]       e_q;
  logic signed [ACC_W-1:0]       na_q, nb_q;
  logic signed [7:0]             sh_q;
  logic signed [KW-1:0]          k_q;
  logic signed [SHV_W-1:0]       vr_q, vi_q;
  logic                          big_q;
  out_item_t                     out_q;

  function automatic logic [6:0] bitlen2(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b);
    logic [6:0] l;
    l = 7'd1;
    for (int i = 0; i < ACC_W - 1; i++) begin
      if ((a[i] ^ a[i+1]) | (b[i] ^ b[i+1])) l = 7'(i + 2);
    end
    return l;
  endfunction

  function automatic logic signed [MANT_W-1:0] napply(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [7:0] s);
    logic signed [ACC_W-1:0] t;
    logic [7:0]              ns;
    ns = 8'(-s);
    if (s >= 0) t = a >>> s;
    else        t = a <<< ns;
    return {t[30], t[30:0]};
  endfunction

  // multiplier operand select
  logic signed [MANT_W-1:0] op_a, op_b;
  logic signed [ACC_W-1:0]  prod;
  always_comb begin
    op_a = pr_q;
    op_b = dr_q;
    if (cmd_i.sc) begin
      op_a = cmd_i.scsel ? pi_q : pr_q;
      op_b = $signed({1'b0, cfg_i.scale_mantissa});
    end else begin
      case (cmd_i.msel)
        MSEL_RE_A: begin op_a = pr_q; op_b = dr_q; end
        MSEL_RE_B: begin op_a = pi_q; op_b = di_q; end
        MSEL_IM_A: begin op_a = pr_q; op_b = di_q; end
        MSEL_IM_B: begin op_a = pi_q; op_b = dr_q; end
        default:   begin op_a = pr_q; op_b = dr_q; end
      endcase
    end
  end
  assign prod = op_a * op_b;

  logic signed [7:0]    sh_new;
  logic [6:0]           blen;
  assign blen   = bitlen2(na_q, nb_q);
  assign sh_new = ((na_q == '0) && (nb_q == '0)) ? 8'sd0 : ($signed({1'b0, blen}) - 8'sd31);

  // final shift toward Q16.16
  logic signed [KW-1:0]    negk;
  logic [5:0]              rsh;
  logic signed [SHV_W-1:0] xr, xi;
  assign negk = -k_q;
  assign rsh  = (negk > KW'(63)) ? 6'd63 : negk[5:0];
  assign xr   = SHV_W'(na_q);
  assign xi   = SHV_W'(nb_q);

  logic [CW-1:0] act_w, ld_w;
  assign act_w = CW'(cfg_i.active_count);
  assign ld_w  = CW'(loaded_q);

  logic load_ok;
  assign load_ok = 32'(in_item_i.index) < 32'(MAX_NODES);

  function automatic logic signed [COORD_WIDTH:0] clampq(input logic signed [ACC_W-1:0] x,
                                                         input logic signed [SHV_W-1:0] v,
                                                         input logic big);
    logic signed [COORD_WIDTH-1:0] r;
    logic                          s;
    r = '0;
    s = 1'b0;
    if (x != '0) begin
      if (big) begin
        s = 1'b1;
        r = x[ACC_W-1] ? Q_MIN[COORD_WIDTH-1:0] : Q_MAX[COORD_WIDTH-1:0];
      end else if (v > Q_MAX) begin
        s = 1'b1;
        r = Q_MAX[COORD_WIDTH-1:0];
      end else if (v < Q_MIN) begin
        s = 1'b1;
        r = Q_MIN[COORD_WIDTH-1:0];
      end else begin
        r = v[COORD_WIDTH-1:0];
      end
    end
    return {r, s};
  endfunction

  logic signed [COORD_WIDTH:0] cl_re, cl_im;
  assign cl_re = clampq(na_q, vr_q, big_q);
  assign cl_im = clampq(nb_q, vi_q, big_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_ok) begin
      mem[AW'(in_item_i.index)] <= {in_item_i.value_re, in_item_i.value_im};
    end
    if (cmd_i.rd) rdata_q <= mem[i_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      n_q      <= '0;
      i_q      <= '0;
    end else begin
      if (cmd_i.load && load_ok && (CNT_W'(in_item_i.index) >= loaded_q)) begin
        loaded_q <= CNT_W'(in_item_i.index) + CNT_W'(1);
      end
      if (cmd_i.start) begin
        n_q <= CNT_W'((act_w < ld_w) ? act_w : ld_w);
        i_q <= '0;
      end
      if (cmd_i.nap_p) i_q <= i_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      z_re_q <= in_item_i.value_re;
      z_im_q <= in_item_i.value_im;
      pr_q   <= 32'sd1073741824;
      pi_q   <= '0;
      e_q    <= -EXP_W'(30);
    end
    if (cmd_i.diff) begin
      na_q <= ACC_W'(z_re_q) - ACC_W'($signed(rdata_q[2*COORD_WIDTH-1:COORD_WIDTH]));
      nb_q <= ACC_W'(z_im_q) - ACC_W'($signed(rdata_q[COORD_WIDTH-1:0]));
    end
    if (cmd_i.ncnt) sh_q <= sh_new;
    if (cmd_i.nap_d) begin
      dr_q <= napply(na_q, sh_q);
      di_q <= napply(nb_q, sh_q);
      e_q  <= e_q - EXP_W'(16) + EXP_W'(sh_q);
    end
    if (cmd_i.mul) begin
      case (cmd_i.msel)
        MSEL_RE_A: na_q <= prod;
        MSEL_RE_B: na_q <= na_q - prod;
        MSEL_IM_A: nb_q <= prod;
        MSEL_IM_B: nb_q <= nb_q + prod;
        default:   na_q <= prod;
      endcase
    end
    if (cmd_i.nap_p) begin
      pr_q <= napply(na_q, sh_q);
      pi_q <= napply(nb_q, sh_q);
      e_q  <= e_q + EXP_W'(sh_q);
    end
    if (cmd_i.sc) begin
      if (cmd_i.scsel) begin
        nb_q <= prod;
      end else begin
        na_q <= prod;
        k_q  <= KW'(e_q) + KW'(cfg_i.scale_exponent) - KW'(14);
      end
    end
    if (cmd_i.shf) begin
      if (k_q < 0) begin
        vr_q  <= xr >>> rsh;
        vi_q  <= xi >>> rsh;
        big_q <= 1'b0;
      end else begin
        vr_q  <= xr <<< k_q[4:0];
        vi_q  <= xi <<< k_q[4:0];
        big_q <= (k_q > KW'(31));
      end
    end
    if (cmd_i.outld) begin
      out_q.result_re <= cl_re[COORD_WIDTH:1];
      out_q.result_im <= cl_im[COORD_WIDTH:1];
      out_q.overflow  <= cl_re[0] | cl_im[0];
    end
  end

  assign sts_o.nodes_done = (i_q >= n_q);
  assign out_item_o       = out_q;

endmodule

`default_nettype wire

FILE: src/leja_polynomial_evaluator.sv
// ----------------------------------------------------------------------------
// leja_polynomial_evaluator
// Evaluates C * prod (z - p_i) over the first N stored complex nodes.
// A load item is written while the block stays idle. An evaluate item runs
// the per-node sequence around the one shared 32x32 multiplier and
// normalizer for each of the N used nodes, then scales and saturates.
// One item at a time; a finished result waits in the output register while
// the next item is taken. Async active-low reset: no nodes loaded, control,
// counter and config registers at defaults; the node memory has no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module leja_polynomial_evaluator
  import lpe_pkg::*;
#(
  parameter int unsigned MAX_NODES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_item_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  lpe_cfg_t cfg_q;
  lpe_cmd_t cmd;
  lpe_sts_t sts;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_count   <= '0;
      cfg_q.scale_mantissa <= SCALE_MANT_RESET;
      cfg_q.scale_exponent <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_ACTIVE_COUNT:   cfg_q.active_count   <= pwdata[8:0];
        REG_SCALE_MANTISSA: cfg_q.scale_mantissa <= pwdata[30:0];
        REG_SCALE_EXPONENT: cfg_q.scale_exponent <= $signed(pwdata[7:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ACTIVE_COUNT:   prdata = {23'd0, cfg_q.active_count};
      REG_SCALE_MANTISSA: prdata = {1'b0, cfg_q.scale_mantissa};
      REG_SCALE_EXPONENT: prdata = {24'd0, cfg_q.scale_exponent};
      default:            prdata = '0;
    endcase
  end

  lpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_item_i.operation),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lpe_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

FILE: test/tb_leja_polynomial_evaluator.sv
// ----------------------------------------------------------------------------
// tb_leja_polynomial_evaluator
// Self-checking bench: loads complex nodes, evaluates the scaled node product
// at query points under several scale and count settings, and compares every
// result with a block floating point predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_leja_polynomial_evaluator;
  import lpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES     = 256;
  localparam int WDOG_MAX  = 20000;
  localparam int LONG_HOLD = 400;
  localparam longint M_HI = 64'sd1073741823;
  localparam longint M_LO = -64'sd1073741824;
  localparam longint H_HI = 64'sd536870911;
  localparam longint H_LO = -64'sd536870912;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  leja_polynomial_evaluator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  in_item_t  pend_q[$];
  out_item_t expect_q[$];
  longint    node_re[NODES];
  longint    node_im[NODES];
  int        loaded_cnt = 0;
  int        cfg_active = 0;
  longint    cfg_mant = 64'd1073741824;
  int        cfg_exp = 0;
  int        errors = 0;
  bit        tx_idle_en = 1'b0, rx_idle_en = 1'b0;
  bit        long_hold_req = 1'b0, long_hold_done = 1'b0;
  int        tx_gap = 0, rx_wait = 0, wdog = 0;

  initial forever #2 clk_i = ~clk_i;

  function automatic void norm(ref longint a, ref longint b, ref int e);
    while (a < M_LO || a > M_HI || b < M_LO || b > M_HI) begin
      a = a >>> 1;
      b = b >>> 1;
      e++;
    end
    if (a == 0 && b == 0) return;
    while (a >= H_LO && a <= H_HI && b >= H_LO && b <= H_HI) begin
      a = a * 2;
      b = b * 2;
      e--;
    end
  endfunction

  function automatic logic [31:0] sat_q16(longint x, int k, ref bit sat);
    longint maxv, minv, r, mag;
    maxv = 64'sd2147483647;
    minv = -64'sd2147483648;
    if (x == 0) return '0;
    if (k < 0) begin
      r = x >>> ((k < -63) ? 63 : -k);
      if (r > maxv) begin sat = 1; return maxv[31:0]; end
      if (r < minv) begin sat = 1; return minv[31:0]; end
      return r[31:0];
    end
    if (x > 0) begin
      if (k > 62 || x > (maxv >>> k)) begin sat = 1; return maxv[31:0]; end
      r = x <<< k;
      return r[31:0];
    end
    mag = -x;
    if (k > 62 || mag > (64'sd2147483648 >>> k)) begin sat = 1; return minv[31:0]; end
    r = -(mag <<< k);
    return r[31:0];
  endfunction

  function automatic void predict_item(in_item_t it);
    longint zr, zi, pr, pi, dr, di, nr, ni;
    int n, e, ed, k;
    bit sat;
    out_item_t res;
    zr = longint'(it.value_re);
    zi = longint'(it.value_im);
    if (it.operation == OP_LOAD) begin
      node_re[it.index] = zr;
      node_im[it.index] = zi;
      if (int'(it.index) + 1 > loaded_cnt) loaded_cnt = int'(it.index) + 1;
      return;
    end
    pr = 64'sd1073741824;
    pi = 0;
    e = -30;
    sat = 0;
    n = (cfg_active < loaded_cnt) ? cfg_active : loaded_cnt;
    for (int i = 0; i < n; i++) begin
      if (pr == 0 && pi == 0) break;
      dr = zr - node_re[i];
      di = zi - node_im[i];
      ed = -16;
      norm(dr, di, ed);
      nr = pr * dr - pi * di;
      ni = pr * di + pi * dr;
      e += ed;
      pr = nr;
      pi = ni;
      norm(pr, pi, e);
    end
    k = e + cfg_exp - 14;
    res.result_re = sat_q16(pr * cfg_mant, k, sat);
    res.result_im = sat_q16(pi * cfg_mant, k, sat);
    res.overflow = sat;
    expect_q = {expect_q, res};
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (pend_q.size() > 0) begin
        in_item <= pend_q.pop_front();
        in_valid <= 1'b1;
        tx_gap <= tx_idle_en ? $urandom_range(0, 17) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i)
    if (rst_ni && in_valid && in_ready) predict_item(in_item);

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    int nxt;
    out_item_t exp_item;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else begin
      nxt = rx_wait;
      if (out_valid && out_ready) begin
        if (expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item re=%h im=%h ovf=%b", $time,
                   out_item.result_re, out_item.result_im, out_item.overflow);
        end else begin
          exp_item = expect_q.pop_front();
          if (exp_item.result_re !== out_item.result_re ||
              exp_item.result_im !== out_item.result_im ||
              exp_item.overflow !== out_item.overflow) begin
            errors++;
            $display("%0t: mismatch expected re=%h im=%h ovf=%b actual re=%h im=%h ovf=%b",
                     $time, exp_item.result_re, exp_item.result_im, exp_item.overflow,
                     out_item.result_re, out_item.result_im, out_item.overflow);
          end
        end
        nxt = rx_idle_en ? $urandom_range(0, 17) : 0;
      end
      if (long_hold_req && !long_hold_done) begin
        nxt = LONG_HOLD;
        long_hold_done <= 1'b1;
      end
      if (nxt > 0) begin
        out_ready <= 1'b0;
        rx_wait <= nxt - 1;
      end else begin
        out_ready <= 1'b1;
        rx_wait <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && pend_q.size() == 0 && expect_q.size() == 0)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_MAX) begin
      $display("** leja_polynomial_evaluator: FAILED **");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(int act, longint mant, int ex);
    reg_write(REG_ACTIVE_COUNT, 32'(act));
    reg_write(REG_SCALE_MANTISSA, 32'(mant));
    reg_write(REG_SCALE_EXPONENT, 32'(ex) & 32'hFF);
    cfg_active = act;
    cfg_mant = mant;
    cfg_exp = ex;
  endtask

  task automatic wait_idle(int tail);
    while (pend_q.size() != 0 || in_valid || expect_q.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
      2: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
      default: return 32'($signed($urandom_range(0, 32'h1FFF)) - 32'sh1000);
    endcase
  endfunction

  function automatic void push_item(logic op, logic [7:0] idx, logic [31:0] re,
                                    logic [31:0] im);
    in_item_t it;
    it.operation = op;
    it.index = idx;
    it.value_re = re;
    it.value_im = im;
    pend_q = {pend_q, it};
  endfunction

  int pick;
  logic [31:0] qre, qim;

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // empty product at reset settings, then nodes at the coordinate extremes
    push_item(OP_EVAL, 8'd0, 32'h0, 32'h0);
    push_item(OP_EVAL, 8'hFF, 32'h7FFFFFFF, 32'h80000000);
    push_item(OP_LOAD, 8'd0, 32'h0, 32'h0);
    push_item(OP_LOAD, 8'd1, 32'h7FFFFFFF, 32'h80000000);
    push_item(OP_LOAD, 8'd2, 32'h80000000, 32'h7FFFFFFF);
    push_item(OP_LOAD, 8'd3, 32'h00010000, 32'hFFFF0000);
    push_item(OP_EVAL, 8'd0, 32'h00010000, 32'h00010000);
    wait_idle(20);

    set_config(4, 64'h7FFFFFFF, 127);
    push_item(OP_EVAL, 8'd0, 32'h00000001, 32'h0);
    push_item(OP_EVAL, 8'd0, 32'h0, 32'h0);
    push_item(OP_EVAL, 8'd0, 32'h80000000, 32'h80000000);
    push_item(OP_EVAL, 8'd0, 32'h7FFFFFFF, 32'h7FFFFFFF);
    wait_idle(20);

    set_config(3, 64'd1073741824, -128);
    push_item(OP_EVAL, 8'd0, 32'h00008000, 32'h00004000);
    push_item(OP_EVAL, 8'd0, 32'h80000000, 32'h7FFFFFFF);
    wait_idle(20);

    set_config(256, 64'd0, -20);
    push_item(OP_EVAL, 8'd0, 32'h12345678, 32'h9ABCDEF0);
    wait_idle(20);

    set_config(2, 64'd1073741824, 0);
    push_item(OP_EVAL, 8'd0, 32'h00020000, 32'h0);
    push_item(OP_EVAL, 8'd0, 32'hFFFF8000, 32'h00001000);
    wait_idle(20);

    // fill every slot, then a few evaluations over all of them
    tx_idle_en = 1;
    rx_idle_en = 1;
    for (int i = 4; i < NODES; i++)
      push_item(OP_LOAD, 8'(i), 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000),
                32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000));
    wait_idle(20);
    set_config(256, 64'd1073741824, -128);
    for (int i = 0; i < 3; i++) push_item(OP_EVAL, 8'($urandom()), rand_coord(), rand_coord());
    wait_idle(20);

    for (int ph = 0; ph < 8; ph++) begin
      if ($urandom_range(0, 3) == 0)
        set_config($urandom_range(0, 1) ? 0 : $urandom_range(0, 40), $urandom_range(0, 32'h7FFFFFFF),
                   $urandom_range(0, 1) ? -128 : 127);
      else
        set_config($urandom_range(0, 12), $urandom_range(0, 32'h7FFFFFFF),
                   $signed($urandom_range(0, 40)) - 20);
      tx_idle_en = ph[0];
      rx_idle_en = ph[1] | ph[2];
      if (ph == 2) long_hold_req = 1'b1;
      for (int j = 0; j < 165; j++) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          push_item(OP_LOAD, 8'($urandom()), rand_coord(), rand_coord());
        end else begin
          qre = rand_coord();
          qim = rand_coord();
          if (pick == 2) begin
            pick = $urandom_range(0, 11);
            qre = node_re[pick][31:0];
            qim = node_im[pick][31:0];
          end
          push_item(OP_EVAL, 8'($urandom()), qre, qim);
        end
      end
      wait_idle(20);
    end

    wait_idle(50);
    if (errors == 0 && expect_q.size() == 0) begin
      $display("** leja_polynomial_evaluator: PASSED **");
    end else begin
      $display("** leja_polynomial_evaluator: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
src/lpe_pkg.sv
src/lpe_ctrl.sv
src/lpe_dp.sv
src/leja_polynomial_evaluator.sv
test/tb_leja_polynomial_evaluator.sv
